// ===== rtl/linear_probe_hash_map_assert.svh =====
// Assertion macros for the linear probe hash map.
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define LPHM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define LPHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lphm_pkg.sv =====
// Shared codes and controller/datapath interface types for the hash map.
package lphm_pkg;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_REFUSED  = 2'd3;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    localparam int HASH_W  = 32;
    localparam int FIELD_W = 32;
    localparam int CNT_W   = 9;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_INIT,
        WR_RBCLR,
        WR_UPDATE,
        WR_TOMB,
        WR_INSERT,
        WR_REBUILD
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PROBE,
        RD_OLD
    } rd_sel_t;

    typedef struct packed {
        logic       ld_item;
        logic       sweep_step;
        logic       init_table;
        logic       prb_init;
        logic       prb_free;    // probe stops at first non-live slot
        logic       prb_new;     // probe the rebuild bank
        logic       prb_step;
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        logic       live_inc;
        logic       live_dec;
        logic       vout_load;
        logic       rb_init;
        logic       clr_step;
        logic       rb_step;
        logic       reb_latch;
        logic       rb_commit;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_found;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic is_set;
        logic is_remove;
        logic size_zero;
        logic prb_hit;
        logic prb_miss;
        logic prb_last;
        logic grow;
        logic shrink;
        logic grow_over;
        logic size_one;
        logic rbclr_last;
        logic rb_last;
        logic rd_live;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/lphm_dp.sv =====
// Datapath: slot memory, table registers, probe and rebuild counters, result beat.
module lphm_dp #(
    parameter int MAX_SLOTS  = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lphm_pkg::dp_cmd_t        cmd,
    output lphm_pkg::dp_stat_t       stat,
    input  logic [1:0]               in_command,
    input  logic [31:0]              in_key,
    input  logic [31:0]              in_hash,
    input  logic [31:0]              in_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               out_status,
    output logic                     out_found,
    output logic [31:0]              out_value,
    output logic [8:0]               out_count,
    output logic [8:0]               out_size
);

    localparam int KW   = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int HW   = lphm_pkg::HASH_W;
    localparam int EW   = 2 + HW + VW + KW;
    localparam int HOFS = KW + VW;
    localparam int MOFS = KW + VW + HW;
    localparam int DEP  = 2 * MAX_SLOTS;
    localparam int AW   = $clog2(DEP);
    localparam int IW   = $clog2(MAX_SLOTS);
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int FW   = CW + 3;

    logic [EW-1:0] mem [DEP];
    logic [EW-1:0] rd_q;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [CW-1:0] size_reg, size_next;
    logic [CW-1:0] live_reg, live_next;
    logic          bank_reg, bank_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          m_valid_reg, m_valid_next;

    logic [1:0]    cmd_reg;
    logic [KW-1:0] key_reg;
    logic [HW-1:0] hash_reg;
    logic [VW-1:0] val_reg;
    logic [VW-1:0] vout_reg;
    logic [EW-1:0] reb_reg;
    logic          nbank_reg;
    logic [CW-1:0] nsize_reg;
    logic [IW-1:0] clr_reg;
    logic [IW-1:0] ri_reg;
    logic [IW-1:0] pidx_reg;
    logic [IW-1:0] steps_reg;
    logic          pbank_reg;
    logic [CW-1:0] psize_reg;
    logic          pfree_reg;
    logic [1:0]    ost_reg;
    logic          ofound_reg;
    logic [VW-1:0] oval_reg;
    logic [CW-1:0] ocnt_reg;
    logic [CW-1:0] osize_reg;

    logic [1:0]    rd_mark;
    logic [CW:0]   items;
    logic [FW-1:0] items4;
    logic [FW-1:0] size3;
    logic [FW-1:0] size2;
    logic [CW:0]   size_dbl;
    logic [IW-1:0] pmask;
    logic [CW-1:0] sel_size;
    logic [HW-1:0] sel_hash;

    function automatic logic [AW-1:0] addr_of(input logic bank, input logic [IW-1:0] idx);
        addr_of = bank ? (AW'(MAX_SLOTS) + AW'(idx)) : AW'(idx);
    endfunction

    assign rd_mark  = rd_q[MOFS +: 2];
    assign items    = (cmd_reg == lphm_pkg::CMD_SET) ? ({1'b0, live_reg} + (CW+1)'(1))
                                                     : {1'b0, live_reg};
    assign items4   = FW'(items) << 2;
    assign size3    = FW'(size_reg) * FW'(3);
    assign size2    = FW'(size_reg) << 1;
    assign size_dbl = {size_reg, 1'b0};
    assign pmask    = IW'(psize_reg - CW'(1));
    assign sel_size = cmd.prb_new ? nsize_reg : size_reg;
    assign sel_hash = cmd.prb_new ? reb_reg[HOFS +: HW] : hash_reg;

    always_comb begin
        stat.sweep_last = (sweep_reg == AW'(DEP - 1));
        stat.is_set     = (cmd_reg == lphm_pkg::CMD_SET);
        stat.is_remove  = (cmd_reg == lphm_pkg::CMD_REMOVE);
        stat.size_zero  = (size_reg == '0);
        stat.prb_hit    = pfree_reg ? (rd_mark != lphm_pkg::MARK_LIVE)
                                    : ((rd_mark == lphm_pkg::MARK_LIVE) &&
                                       (rd_q[KW-1:0] == key_reg));
        stat.prb_miss   = !pfree_reg && (rd_mark == lphm_pkg::MARK_EMPTY);
        stat.prb_last   = ((CW'(steps_reg) + CW'(1)) == psize_reg);
        stat.grow       = (items4 >= size3);
        stat.shrink     = (items4 < size2);
        stat.grow_over  = (size_dbl > (CW+1)'(MAX_SLOTS));
        stat.size_one   = (size_reg == CW'(1));
        stat.rbclr_last = ((CW'(clr_reg) + CW'(1)) == nsize_reg);
        stat.rb_last    = ((CW'(ri_reg) + CW'(1)) == size_reg);
        stat.rd_live    = (rd_mark == lphm_pkg::MARK_LIVE);
        stat.out_free   = !m_valid_reg || out_ready;
    end

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = addr_of(pbank_reg, pidx_reg);
        unique case (cmd.rd_sel)
            lphm_pkg::RD_PROBE: rd_addr = addr_of(pbank_reg, pidx_reg);
            lphm_pkg::RD_OLD:   rd_addr = addr_of(bank_reg, ri_reg);
            default:            rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = addr_of(pbank_reg, pidx_reg);
        wr_data = {lphm_pkg::MARK_EMPTY, (EW-2)'(0)};
        unique case (cmd.wr_sel)
            lphm_pkg::WR_CLEAR: wr_addr = sweep_reg;
            lphm_pkg::WR_INIT:  wr_addr = addr_of(bank_reg, '0);
            lphm_pkg::WR_RBCLR: wr_addr = addr_of(nbank_reg, clr_reg);
            lphm_pkg::WR_UPDATE:
                wr_data = {lphm_pkg::MARK_LIVE, rd_q[HOFS +: HW], val_reg, rd_q[KW-1:0]};
            lphm_pkg::WR_TOMB:
                wr_data = {lphm_pkg::MARK_TOMB, rd_q[EW-3:0]};
            lphm_pkg::WR_INSERT:
                wr_data = {lphm_pkg::MARK_LIVE, hash_reg, val_reg, key_reg};
            lphm_pkg::WR_REBUILD:
                wr_data = {lphm_pkg::MARK_LIVE, reb_reg[EW-3:0]};
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    always_comb begin
        size_next    = size_reg;
        live_next    = live_reg;
        bank_next    = bank_reg;
        sweep_next   = sweep_reg;
        m_valid_next = m_valid_reg;
        if (cmd.sweep_step) begin
            sweep_next = sweep_reg + AW'(1);
        end
        if (cmd.init_table) begin
            size_next = CW'(1);
            live_next = '0;
        end
        if (cmd.live_inc) begin
            live_next = live_reg + CW'(1);
        end
        if (cmd.live_dec && (live_reg != '0)) begin
            live_next = live_reg - CW'(1);
        end
        if (cmd.rb_commit) begin
            bank_next = nbank_reg;
            size_next = nsize_reg;
        end
        if (m_valid_reg && out_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= '0;
            live_reg    <= '0;
            bank_reg    <= 1'b0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            size_reg    <= size_next;
            live_reg    <= live_next;
            bank_reg    <= bank_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            cmd_reg  <= in_command;
            key_reg  <= in_key[KW-1:0];
            hash_reg <= in_hash;
            val_reg  <= in_value[VW-1:0];
            vout_reg <= '0;
        end
        if (cmd.vout_load) begin
            vout_reg <= rd_q[KW +: VW];
        end
        if (cmd.prb_init) begin
            pbank_reg <= cmd.prb_new ? nbank_reg : bank_reg;
            psize_reg <= sel_size;
            pfree_reg <= cmd.prb_free;
            pidx_reg  <= sel_hash[IW-1:0] & IW'(sel_size - CW'(1));
            steps_reg <= '0;
        end
        if (cmd.prb_step) begin
            pidx_reg  <= (pidx_reg + IW'(1)) & pmask;
            steps_reg <= steps_reg + IW'(1);
        end
        if (cmd.rb_init) begin
            nbank_reg <= !bank_reg;
            nsize_reg <= stat.grow ? CW'(size_dbl) : (size_reg >> 1);
            clr_reg   <= '0;
            ri_reg    <= '0;
        end
        if (cmd.clr_step) begin
            clr_reg <= clr_reg + IW'(1);
        end
        if (cmd.rb_step) begin
            ri_reg <= ri_reg + IW'(1);
        end
        if (cmd.reb_latch) begin
            reb_reg <= rd_q;
        end
        if (cmd.res_load) begin
            ost_reg    <= cmd.res_status;
            ofound_reg <= cmd.res_found;
            oval_reg   <= vout_reg;
            ocnt_reg   <= live_reg;
            osize_reg  <= size_reg;
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_status = ost_reg;
    assign out_found  = ofound_reg;
    assign out_value  = 32'(oval_reg);
    assign out_count  = 9'(ocnt_reg);
    assign out_size   = 9'(osize_reg);

endmodule

// ===== rtl/lphm_ctrl.sv =====
// Controller: sequences clear pass, probes, resize rebuilds and result beats.
module lphm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lphm_pkg::dp_stat_t  stat,
    output lphm_pkg::dp_cmd_t   cmd
);

    typedef enum logic [15:0] {
        S_SWEEP     = 16'h0001,
        S_IDLE      = 16'h0002,
        S_START     = 16'h0004,
        S_FIND_INIT = 16'h0008,
        S_PRB_RD    = 16'h0010,
        S_PRB_CHK   = 16'h0020,
        S_FIND_END  = 16'h0040,
        S_RSZ       = 16'h0080,
        S_RB_CLR    = 16'h0100,
        S_RB_RD     = 16'h0200,
        S_RB_CHK    = 16'h0400,
        S_REB_END   = 16'h0800,
        S_RB_FIN    = 16'h1000,
        S_FREE_INIT = 16'h2000,
        S_FREE_END  = 16'h4000,
        S_DONE      = 16'h8000
    } state_t;

    typedef enum logic [2:0] {
        PH_FIND = 3'b001,
        PH_FREE = 3'b010,
        PH_REB  = 3'b100
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       hit_reg, hit_next;
    logic [1:0] st_reg, st_next;
    logic       found_reg, found_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        hit_next   = hit_reg;
        st_next    = st_reg;
        found_next = found_reg;
        cmd        = '0;
        cmd.rd_sel = lphm_pkg::RD_NONE;
        cmd.wr_sel = lphm_pkg::WR_NONE;
        cmd.res_status = st_reg;
        cmd.res_found  = found_reg;
        unique case (state_reg)
            S_SWEEP: begin
                cmd.wr_sel     = lphm_pkg::WR_CLEAR;
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.ld_item = 1'b1;
                    st_next     = lphm_pkg::ST_NOTFOUND;
                    found_next  = 1'b0;
                    state_next  = S_START;
                end
            end
            S_START: begin
                if (!stat.size_zero) begin
                    state_next = S_FIND_INIT;
                end else if (stat.is_set || stat.is_remove) begin
                    cmd.init_table = 1'b1;
                    cmd.wr_sel     = lphm_pkg::WR_INIT;
                    state_next     = S_FIND_INIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_FIND_INIT: begin
                cmd.prb_init = 1'b1;
                phase_next   = PH_FIND;
                state_next   = S_PRB_RD;
            end
            S_PRB_RD: begin
                cmd.rd_sel = lphm_pkg::RD_PROBE;
                state_next = S_PRB_CHK;
            end
            S_PRB_CHK: begin
                if (stat.prb_hit || stat.prb_miss || stat.prb_last) begin
                    hit_next = stat.prb_hit;
                    unique case (phase_reg)
                        PH_FIND: state_next = S_FIND_END;
                        PH_FREE: state_next = S_FREE_END;
                        PH_REB:  state_next = S_REB_END;
                        default: state_next = S_FIND_END;
                    endcase
                end else begin
                    cmd.prb_step = 1'b1;
                    state_next   = S_PRB_RD;
                end
            end
            S_FIND_END: begin
                if (stat.is_set) begin
                    if (hit_reg) begin
                        cmd.wr_sel = lphm_pkg::WR_UPDATE;
                        st_next    = lphm_pkg::ST_OK;
                        found_next = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_RSZ;
                    end
                end else if (stat.is_remove) begin
                    if (hit_reg) begin
                        cmd.wr_sel   = lphm_pkg::WR_TOMB;
                        cmd.live_dec = 1'b1;
                        found_next   = 1'b1;
                        state_next   = S_RSZ;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    if (hit_reg) begin
                        cmd.vout_load = 1'b1;
                        st_next       = lphm_pkg::ST_OK;
                        found_next    = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_RSZ: begin
                st_next = lphm_pkg::ST_OK;
                if (stat.grow && stat.grow_over) begin
                    st_next    = lphm_pkg::ST_FULL;
                    state_next = S_DONE;
                end else if (!stat.grow && stat.shrink && stat.size_one) begin
                    st_next    = lphm_pkg::ST_REFUSED;
                    state_next = S_DONE;
                end else if (stat.grow || stat.shrink) begin
                    cmd.rb_init = 1'b1;
                    state_next  = S_RB_CLR;
                end else if (stat.is_set) begin
                    state_next = S_FREE_INIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RB_CLR: begin
                cmd.wr_sel   = lphm_pkg::WR_RBCLR;
                cmd.clr_step = 1'b1;
                if (stat.rbclr_last) begin
                    state_next = S_RB_RD;
                end
            end
            S_RB_RD: begin
                cmd.rd_sel = lphm_pkg::RD_OLD;
                state_next = S_RB_CHK;
            end
            S_RB_CHK: begin
                if (stat.rd_live) begin
                    cmd.reb_latch = 1'b1;
                    state_next    = S_RB_FIN;
                    phase_next    = PH_REB;
                    state_next    = S_FREE_INIT;
                end else if (stat.rb_last) begin
                    state_next = S_RB_FIN;
                end else begin
                    cmd.rb_step = 1'b1;
                    state_next  = S_RB_RD;
                end
            end
            S_REB_END: begin
                if (hit_reg) begin
                    cmd.wr_sel = lphm_pkg::WR_REBUILD;
                end
                if (stat.rb_last) begin
                    state_next = S_RB_FIN;
                end else begin
                    cmd.rb_step = 1'b1;
                    state_next  = S_RB_RD;
                end
            end
            S_RB_FIN: begin
                cmd.rb_commit = 1'b1;
                phase_next    = PH_FIND;
                state_next    = stat.is_set ? S_FREE_INIT : S_DONE;
            end
            S_FREE_INIT: begin
                // rebuild moves probe the new bank with the held entry's hash
                cmd.prb_init = 1'b1;
                cmd.prb_free = 1'b1;
                cmd.prb_new  = (phase_reg == PH_REB);
                if (phase_reg != PH_REB) begin
                    phase_next = PH_FREE;
                end
                state_next = S_PRB_RD;
            end
            S_FREE_END: begin
                if (hit_reg) begin
                    cmd.wr_sel   = lphm_pkg::WR_INSERT;
                    cmd.live_inc = 1'b1;
                    st_next      = lphm_pkg::ST_OK;
                end else begin
                    st_next = lphm_pkg::ST_FULL;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            phase_reg <= PH_FIND;
            hit_reg   <= 1'b0;
            st_reg    <= lphm_pkg::ST_OK;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            hit_reg   <= hit_next;
            st_reg    <= st_next;
            found_reg <= found_next;
        end
    end

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// Linear probing hash map with tombstones; top level joining controller and datapath.
// One command per beat, one result beat per command. After reset the slot memory of
// both banks is swept clear before the first beat is taken. A lookup or an update
// probes slot after slot, each slot as a registered read of the slot memory, then a
// compare. An insert or remove that resizes first clears the new table, then reads
// every old slot and probes the new table for each live entry that it moves, plus a
// free-slot probe on insert.
module linear_probe_hash_map #(
    parameter int MAX_SLOTS  = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], key[33:2], key_hash[65:34], value[97:66], zero fill
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], found[2], value_out[34:3], item_count[43:35], table_size[52:44], zero
    output logic [55:0]  m_tdata
);

    lphm_pkg::dp_cmd_t  cmd;
    lphm_pkg::dp_stat_t stat;
    logic [1:0]  o_status;
    logic        o_found;
    logic [31:0] o_value;
    logic [8:0]  o_count;
    logic [8:0]  o_size;

    lphm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lphm_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_command (s_tdata[1:0]),
        .in_key     (s_tdata[33:2]),
        .in_hash    (s_tdata[65:34]),
        .in_value   (s_tdata[97:66]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (o_status),
        .out_found  (o_found),
        .out_value  (o_value),
        .out_count  (o_count),
        .out_size   (o_size)
    );

    assign m_tdata = {3'b000, o_size, o_count, o_value, o_found, o_status};

`include "linear_probe_hash_map_assert.svh"

    `LPHM_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "beat taken while busy")
    `LPHM_ASSERT_NOW(a_size_pow2, m_tvalid, $countones(m_tdata[52:44]) <= 1, "size not power of two")
    `LPHM_ASSERT_NOW(a_miss_not_found, m_tvalid && (m_tdata[1:0] == lphm_pkg::ST_NOTFOUND), !m_tdata[2], "miss flagged found")

endmodule
